[rtl/core/rsst_pkg.sv]
// Package with the shared widths, codes and control structs of the range sum segment tree.
package rsst_pkg;

  localparam int unsigned LeafBits = 8;
  localparam int unsigned NodeBits = LeafBits + 1;
  localparam int unsigned CursorBits = LeafBits + 2;
  localparam int unsigned DataW = 32;
  localparam int unsigned InDataW = 48;

  localparam logic [CursorBits-1:0] LeafBase = CursorBits'(1) << LeafBits;
  localparam logic [CursorBits-1:0] RootNode = CursorBits'(1);

  localparam logic FuncUpdate = 1'b0;
  localparam logic FuncQuery = 1'b1;

  typedef struct packed {
    logic clr_step;
    logic load;
    logic rd_l;
    logic rd_r_dec;
    logic acc;
    logic inc_l;
    logic shift;
    logic upd_leaf;
    logic upd_node;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic l_lt_r;
    logic l_odd;
    logic r_odd;
    logic l_root;
    logic out_free;
  } status_t;

endpackage

[rtl/core/rsst_datapath.sv]
// Datapath of the range sum segment tree: node memory, cursors, accumulator and result register.
module rsst_datapath
  import rsst_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_t                cmd_i,
  output status_t             status_o,
  input  logic [LeafBits-1:0] first_index_i,
  input  logic [LeafBits-1:0] last_index_i,
  input  logic [DataW-1:0]    new_value_i,
  input  logic                m_tready_i,
  output logic                m_tvalid_o,
  output logic [DataW-1:0]    m_tdata_o
);

  logic [DataW-1:0]      mem [2**NodeBits];
  logic [DataW-1:0]      rdata_q;
  logic [NodeBits-1:0]   rd_addr;
  logic                  wr_en;
  logic [NodeBits-1:0]   wr_addr;
  logic [DataW-1:0]      wr_data;

  logic [NodeBits-1:0]   clr_cnt_q, clr_cnt_d;
  logic [CursorBits-1:0] l_q, l_d;
  logic [CursorBits-1:0] r_q, r_d;
  logic [CursorBits-1:0] r_dec;
  logic [DataW-1:0]      sum_q, sum_d;
  logic [DataW-1:0]      delta_q, delta_d;
  logic [DataW-1:0]      value_q, value_d;
  logic                  out_valid_q, out_valid_d;
  logic [DataW-1:0]      out_data_q, out_data_d;

  assign r_dec = r_q - CursorBits'(1);
  assign rd_addr = cmd_i.rd_r_dec ? r_dec[NodeBits-1:0] : l_q[NodeBits-1:0];

  always_comb begin
    wr_en = 1'b0;
    wr_addr = l_q[NodeBits-1:0];
    wr_data = value_q;
    if (cmd_i.clr_step) begin
      wr_en = 1'b1;
      wr_addr = clr_cnt_q;
      wr_data = '0;
    end else if (cmd_i.upd_leaf) begin
      wr_en = 1'b1;
    end else if (cmd_i.upd_node) begin
      wr_en = 1'b1;
      wr_data = rdata_q + delta_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_q <= mem[rd_addr];
  end

  always_comb begin
    clr_cnt_d = clr_cnt_q;
    l_d = l_q;
    r_d = r_q;
    sum_d = sum_q;
    delta_d = delta_q;
    value_d = value_q;
    out_valid_d = out_valid_q;
    out_data_d = out_data_q;
    if (cmd_i.clr_step) begin
      clr_cnt_d = clr_cnt_q + NodeBits'(1);
    end
    if (cmd_i.load) begin
      l_d = LeafBase + CursorBits'(first_index_i);
      r_d = LeafBase + CursorBits'(last_index_i) + CursorBits'(1);
      sum_d = '0;
      value_d = new_value_i;
    end
    if (cmd_i.rd_r_dec) begin
      r_d = r_dec;
    end
    if (cmd_i.acc) begin
      sum_d = sum_q + rdata_q;
    end
    if (cmd_i.inc_l) begin
      l_d = l_q + CursorBits'(1);
    end
    if (cmd_i.shift) begin
      l_d = l_q >> 1;
      r_d = r_q >> 1;
    end
    if (cmd_i.upd_leaf) begin
      delta_d = value_q - rdata_q;
      l_d = l_q >> 1;
    end
    if (cmd_i.upd_node) begin
      l_d = l_q >> 1;
    end
    if (m_tready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.load_out) begin
      out_valid_d = 1'b1;
      out_data_d = sum_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
      out_valid_q <= 1'b0;
      sum_q <= '0;
    end else begin
      clr_cnt_q <= clr_cnt_d;
      out_valid_q <= out_valid_d;
      sum_q <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    l_q <= l_d;
    r_q <= r_d;
    delta_q <= delta_d;
    value_q <= value_d;
    out_data_q <= out_data_d;
  end

  assign status_o.clr_done = (clr_cnt_q == '1);
  assign status_o.l_lt_r = (l_q < r_q);
  assign status_o.l_odd = l_q[0];
  assign status_o.r_odd = r_q[0];
  assign status_o.l_root = (l_q == RootNode);
  assign status_o.out_free = !out_valid_q || m_tready_i;

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o = out_data_q;

  a_single_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.rd_l && cmd_i.rd_r_dec))
    else $error("Two node reads requested in one cycle.");

  a_node_in_tree: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.upd_node || cmd_i.upd_leaf) |-> (l_q != '0))
    else $error("Update walked above the root.");

  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> (!out_valid_q || m_tready_i))
    else $error("Result overwritten before it was taken.");

  a_sum_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!cmd_i.acc && !cmd_i.load) |=> (sum_q == $past(sum_q)))
    else $error("Accumulator changed without a command.");

endmodule

[rtl/core/rsst_controller.sv]
// Controller state machine that sequences clearing, updates and queries of the segment tree.
module rsst_controller
  import rsst_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    s_tvalid_i,
  input  logic    func_i,
  input  status_t status_i,
  output logic    s_tready_o,
  output cmd_t    cmd_o
);

  localparam logic [3:0] StClear = 4'd0;
  localparam logic [3:0] StIdle = 4'd1;
  localparam logic [3:0] StUpdRdLeaf = 4'd2;
  localparam logic [3:0] StUpdLeaf = 4'd3;
  localparam logic [3:0] StUpdRdNode = 4'd4;
  localparam logic [3:0] StUpdNode = 4'd5;
  localparam logic [3:0] StQryCheck = 4'd6;
  localparam logic [3:0] StQryAccL = 4'd7;
  localparam logic [3:0] StQryAccR = 4'd8;
  localparam logic [3:0] StDone = 4'd9;

  logic [3:0] state_q, state_d;

  assign s_tready_o = (state_q == StIdle);

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    case (state_q)
      StClear: begin
        cmd_o.clr_step = 1'b1;
        if (status_i.clr_done) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (s_tvalid_i) begin
          cmd_o.load = 1'b1;
          state_d = (func_i == FuncQuery) ? StQryCheck : StUpdRdLeaf;
        end
      end
      StUpdRdLeaf: begin
        cmd_o.rd_l = 1'b1;
        state_d = StUpdLeaf;
      end
      StUpdLeaf: begin
        cmd_o.upd_leaf = 1'b1;
        state_d = StUpdRdNode;
      end
      StUpdRdNode: begin
        cmd_o.rd_l = 1'b1;
        state_d = StUpdNode;
      end
      StUpdNode: begin
        cmd_o.upd_node = 1'b1;
        state_d = status_i.l_root ? StDone : StUpdRdNode;
      end
      StQryCheck: begin
        if (!status_i.l_lt_r) begin
          state_d = StDone;
        end else if (status_i.l_odd) begin
          cmd_o.rd_l = 1'b1;
          state_d = StQryAccL;
        end else if (status_i.r_odd) begin
          cmd_o.rd_r_dec = 1'b1;
          state_d = StQryAccR;
        end else begin
          cmd_o.shift = 1'b1;
        end
      end
      StQryAccL: begin
        cmd_o.acc = 1'b1;
        cmd_o.inc_l = 1'b1;
        state_d = StQryCheck;
      end
      StQryAccR: begin
        cmd_o.acc = 1'b1;
        state_d = StQryCheck;
      end
      StDone: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
    end else begin
      state_q <= state_d;
    end
  end

  a_clear_then_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StClear && status_i.clr_done) |=> (state_q == StIdle))
    else $error("Clearing pass did not end in idle.");

  a_load_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> (state_q == StUpdRdLeaf || state_q == StQryCheck))
    else $error("Accepted transaction did not start a walk.");

  a_update_reads_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.upd_leaf || cmd_o.upd_node) |-> $past(cmd_o.rd_l))
    else $error("Node written without a preceding read.");

endmodule

[rtl/core/range_sum_segment_tree_unit.sv]
// Range sum segment tree over 256 signed 32-bit leaves with point updates and range queries.
// After reset the node memory is cleared, and during that pass no transaction is
// accepted. The unit handles one transaction at a time through a node memory with one read
// port and one write port, using at most one node read or one node write per cycle. A point
// update reads and rewrites the nine nodes from the leaf to the root, one node after the other.
// A range query walks up the tree level by level, reading and adding each node that joins
// the sum. The unit is ready for the next transaction in the cycle after the result is
// loaded. Sums wrap modulo 2^32; an update returns 0, as does a query with first_index above
// last_index.
module range_sum_segment_tree_unit
  import rsst_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_tvalid_i,
  output logic               s_tready_o,
  input  logic [InDataW-1:0] s_tdata_i,  // first_index[7:0], last_index[15:8], new_value[47:16]
  input  logic               s_tuser_i,  // func[0]
  output logic               m_tvalid_o,
  input  logic               m_tready_i,
  output logic [DataW-1:0]   m_tdata_o   // range_sum[31:0]
);

  cmd_t    cmd;
  status_t status;

  rsst_controller u_controller (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .func_i     (s_tuser_i),
    .status_i   (status),
    .s_tready_o (s_tready_o),
    .cmd_o      (cmd)
  );

  rsst_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .first_index_i (s_tdata_i[7:0]),
    .last_index_i  (s_tdata_i[15:8]),
    .new_value_i   (s_tdata_i[47:16]),
    .m_tready_i    (m_tready_i),
    .m_tvalid_o    (m_tvalid_o),
    .m_tdata_o     (m_tdata_o)
  );

endmodule
